### hdl/query_normalize_fnv1a_fingerprint_macros.svh
// ---------------------------------------------------------------------------
// Query fingerprint assertion macros
// Shorthand for the concurrent checks that close the top level.
// ---------------------------------------------------------------------------
`ifndef QUERY_NORMALIZE_FNV1A_FINGERPRINT_MACROS_SVH
`define QUERY_NORMALIZE_FNV1A_FINGERPRINT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QNF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qnf check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QNF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qnf check failed");

`endif

### hdl/qnf_pkg.sv
// ---------------------------------------------------------------------------
// Query fingerprint package
// Shared constants, the token passed from front to back, and the hash step.
// ---------------------------------------------------------------------------
package qnf_pkg;

  localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
  // The prime is 2^40 + 0x1b3; only the low part needs a multiplier.
  localparam int unsigned FNV_SHIFT   = 40;
  localparam logic [8:0]  FNV_MULT_LO = 9'h1b3;

  localparam logic [7:0] CHAR_QUOTE = 8'h27;
  localparam logic [7:0] CHAR_MARK  = 8'h3f;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam int unsigned FIFO_DEPTH_DEFAULT = 4;

  // One normalized unit of work for the hash engine.
  typedef struct packed {
    logic       space;    // Hash a held space before the character.
    logic       ch_vld;   // A character is to be hashed.
    logic [7:0] ch;       // Normalized character.
    logic       eoq;      // End of query after this token.
  } qnf_token_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } qnf_fifo_status_t;

  // One FNV-1a step: xor the byte, then multiply by the 64-bit prime.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    logic [63:0] lo;
    x  = h ^ {56'd0, b};
    lo = x * {55'd0, FNV_MULT_LO};
    return lo + (x << FNV_SHIFT);
  endfunction

endpackage

### hdl/query_normalize_fnv1a_fingerprint.sv
// ---------------------------------------------------------------------------
// Query normalizing FNV-1a fingerprint
// Normalizes a query text byte by byte and hashes it with 64-bit FNV-1a.
// ---------------------------------------------------------------------------
// The front end takes one input item per cycle while the token queue has
// room, and stalls its input while the queue is full. The hash engine
// takes each emitted normalized byte or end-only token from the queue as
// one entry, and hashes a held space that a byte flushes in a separate
// step before the byte; each FNV step is one multiply by the prime. Bytes
// that emit nothing (quoted text, digits after the first, repeated
// whitespace) cost the engine nothing. The fingerprint is loaded into the
// output register when the end token is popped from the head of the queue,
// after any held space that it flushes, once the previous fingerprint has
// left the output register; the next query can be taken while it waits.
module query_normalize_fnv1a_fingerprint #(
  parameter int unsigned FIFO_DEPTH = qnf_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_byte_present,
  input  logic        in_end_of_query,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_fingerprint
);

`include "query_normalize_fnv1a_fingerprint_macros.svh"

  qnf_pkg::qnf_token_t       token;
  qnf_pkg::qnf_token_t       head;
  qnf_pkg::qnf_fifo_status_t fifo_status;
  logic                      take;
  logic                      push;
  logic                      pop;
  logic                      front_idle;

  // An input transfer needs room for a possible token.
  assign in_ready = !fifo_status.full;
  assign take     = in_valid && in_ready;

  qnf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .byte_value   (in_byte_value),
    .byte_present (in_byte_present),
    .end_of_query (in_end_of_query),
    .push         (push),
    .token        (token),
    .idle_state   (front_idle)
  );

  qnf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (token),
    .pop       (pop),
    .head_data (head),
    .status    (fifo_status)
  );

  qnf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_vld        (!fifo_status.empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_fingerprint (out_fingerprint)
  );

  // The queue can never be full and empty at once.
  `QNF_ASSERT_NOW(a_fifo_consistent, 1'b1, !(fifo_status.full && fifo_status.empty))
  // An end-of-query transfer leaves the front end in its reset state.
  `QNF_ASSERT_NEXT(a_front_cleared, take && in_end_of_query, front_idle)
  // The engine never pops an empty queue.
  `QNF_ASSERT_NOW(a_no_pop_empty, pop, !fifo_status.empty)

endmodule

### hdl/qnf_front.sv
// ---------------------------------------------------------------------------
// Query fingerprint front end
// Classifies each accepted byte, tracks quote, digit and whitespace state,
// and produces tokens for the hash engine.
// ---------------------------------------------------------------------------
module qnf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          byte_value,
  input  logic                byte_present,
  input  logic                end_of_query,
  output logic                push,
  output qnf_pkg::qnf_token_t token,
  output logic                idle_state
);

  logic in_quote_r, in_quote_nxt;
  logic in_num_r, in_num_nxt;
  logic last_sp_r, last_sp_nxt;
  logic sp_pend_r, sp_pend_nxt;
  logic       emit;
  logic [7:0] emit_ch;
  logic       is_white;
  logic       is_digit;
  logic       is_upper;

  // Character classes.
  assign is_white = (byte_value == qnf_pkg::CHAR_SPACE) ||
                    ((byte_value >= 8'h09) && (byte_value <= 8'h0d));
  assign is_digit = (byte_value >= 8'h30) && (byte_value <= 8'h39);
  assign is_upper = (byte_value >= 8'h41) && (byte_value <= 8'h5a);

  // Normalization decisions for the current byte.
  always_comb begin
    in_quote_nxt = in_quote_r;
    in_num_nxt   = in_num_r;
    last_sp_nxt  = last_sp_r;
    sp_pend_nxt  = sp_pend_r;
    emit         = 1'b0;
    emit_ch      = qnf_pkg::CHAR_MARK;
    if (byte_present) begin
      if (byte_value == qnf_pkg::CHAR_QUOTE) begin
        in_quote_nxt = !in_quote_r;
        emit         = in_quote_r;
      end else if (!in_quote_r) begin
        if (is_digit) begin
          emit       = !in_num_r;
          in_num_nxt = 1'b1;
        end else begin
          in_num_nxt = 1'b0;
          if (is_white) begin
            if (!last_sp_r) begin
              sp_pend_nxt = 1'b1;
              last_sp_nxt = 1'b1;
            end
          end else begin
            emit    = 1'b1;
            emit_ch = is_upper ? (byte_value + 8'h20) : byte_value;
          end
        end
      end
    end
    if (emit) begin
      sp_pend_nxt = 1'b0;
      last_sp_nxt = 1'b0;
    end
    // The end marker returns every flag to its reset value.
    if (end_of_query) begin
      in_quote_nxt = 1'b0;
      in_num_nxt   = 1'b0;
      last_sp_nxt  = 1'b0;
      sp_pend_nxt  = 1'b0;
    end
  end

  // Token toward the queue.
  always_comb begin
    token.space  = emit && sp_pend_r;
    token.ch_vld = emit;
    token.ch     = emit_ch;
    token.eoq    = end_of_query;
    push         = take && (emit || end_of_query);
  end

  assign idle_state = !in_quote_r && !in_num_r && !last_sp_r && !sp_pend_r;

  // Classification state, updated on each transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quote_r <= 1'b0;
      in_num_r   <= 1'b0;
      last_sp_r  <= 1'b0;
      sp_pend_r  <= 1'b0;
    end else if (take) begin
      in_quote_r <= in_quote_nxt;
      in_num_r   <= in_num_nxt;
      last_sp_r  <= last_sp_nxt;
      sp_pend_r  <= sp_pend_nxt;
    end
  end

endmodule

### hdl/qnf_fifo.sv
// ---------------------------------------------------------------------------
// Query fingerprint token queue
// Short queue that decouples the front end from the hash engine.
// ---------------------------------------------------------------------------
module qnf_fifo #(
  parameter int unsigned DEPTH = qnf_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  qnf_pkg::qnf_token_t       push_data,
  input  logic                      pop,
  output qnf_pkg::qnf_token_t       head_data,
  output qnf_pkg::qnf_fifo_status_t status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  qnf_pkg::qnf_token_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign status.full  = (cnt_r == FULL_CNT);
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_data    = mem[rd_ptr_r];

  // Pointer and count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### hdl/qnf_back.sv
// ---------------------------------------------------------------------------
// Query fingerprint hash engine
// Runs one FNV-1a step per cycle over queued tokens, holding an end token
// while the result is full; registers fingerprints for the result channel.
// ---------------------------------------------------------------------------
module qnf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_vld,
  input  qnf_pkg::qnf_token_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         out_fingerprint
);

  logic [63:0] hash_r, hash_nxt;
  logic        phase_r, phase_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic [63:0] out_fp_r;
  logic        do_space;
  logic        do_final;
  logic        can_finish;
  logic [7:0]  byte_sel;
  logic [63:0] stepped;
  logic [63:0] final_hash;
  logic        load_out;

  // A token with a held space first hashes the space alone.
  assign do_space   = head_vld && head.space && !phase_r;
  assign do_final   = head_vld && !do_space;
  assign byte_sel   = do_space ? qnf_pkg::CHAR_SPACE : head.ch;
  assign stepped    = qnf_pkg::fnv_step(hash_r, byte_sel);
  assign final_hash = head.ch_vld ? stepped : hash_r;
  assign can_finish = !head.eoq || !out_vld_r || out_ready;
  assign pop        = do_final && can_finish;
  assign load_out   = pop && head.eoq;

  // Next hash, phase and result-valid values.
  always_comb begin
    hash_nxt    = hash_r;
    phase_nxt   = phase_r;
    out_vld_nxt = out_vld_r && !out_ready;
    if (do_space) begin
      hash_nxt  = stepped;
      phase_nxt = 1'b1;
    end else if (pop) begin
      hash_nxt  = head.eoq ? qnf_pkg::FNV_BASIS : final_hash;
      phase_nxt = 1'b0;
    end
    if (load_out) begin
      out_vld_nxt = 1'b1;
    end
  end

  // Control state and running hash.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r    <= qnf_pkg::FNV_BASIS;
      phase_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      hash_r    <= hash_nxt;
      phase_r   <= phase_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_fp_r <= final_hash;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_fingerprint = out_fp_r;

endmodule
